// ===== rtl/rcfd_pkg.sv =====
// Shared types, constants and helpers for the four-digit radix converter.
`default_nettype none

package rcfd_pkg;

  localparam int FIELD_COUNT = 4;
  localparam int NUM_DIGITS  = 4;
  localparam int USED_DIGITS = (NUM_DIGITS < FIELD_COUNT) ? NUM_DIGITS : FIELD_COUNT;
  localparam int CHAR_W      = 8;
  localparam int VAL_W       = 16;
  localparam int ACC_W       = VAL_W + 4;
  localparam int DIG_W       = 4;
  localparam int MAX_OUT     = 16;
  localparam int STK_IDX_W   = $clog2(MAX_OUT);
  localparam int NDIG_W      = $clog2(MAX_OUT + 1);
  localparam int IDX_W       = $clog2(FIELD_COUNT);
  localparam int IN_DATA_W   = FIELD_COUNT * CHAR_W;
  localparam int OUT_USER_W  = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;
  localparam logic [CHAR_W-1:0] ASCII_A    = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_F    = 8'd70;
  localparam logic [CHAR_W-1:0] ALPHA_OFS  = 8'd55;
  localparam logic [DIG_W-1:0]  DIG_NINE   = 4'd9;

  // reciprocal of ten, exact for any 16-bit dividend after a shift by 19
  localparam logic [VAL_W-1:0] RECIP_TEN = 16'd52429;
  localparam int               RECIP_SH  = 19;

  localparam logic CFG_IDX_IN  = 1'b0;
  localparam logic CFG_IDX_OUT = 1'b1;

  typedef enum logic [1:0] {
    BASE_BIN,
    BASE_OCT,
    BASE_DEC,
    BASE_HEX
  } base_e;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_CHK,
    STEP_ACC,
    STEP_DIV,
    STEP_EMIT
  } step_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_e;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_BAD,
    JC_MORE_IN,
    JC_QUOT_NZ,
    JC_MORE_OUT
  } jcond_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_ACC,
    OP_DIV,
    OP_EMIT
  } op_e;

  typedef struct packed {
    hold_e  hold;
    op_e    op;
    jcond_e jcond;
    step_e  jump;
    step_e  next;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic bad;
    logic more_in;
    logic quot_nz;
    logic more_out;
  } status_t;

  typedef struct packed {
    op_e  op;
    logic fire;
  } dp_ctrl_t;

  // digit value of an ASCII character; 16 flags anything but 0-9 and A-F
  function automatic logic [DIG_W:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [DIG_W:0] v;
    if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
      v = 5'(c - ASCII_ZERO);
    end else if (c >= ASCII_A && c <= ASCII_F) begin
      v = 5'(c - ALPHA_OFS);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rcfd_ucode_rom.sv =====
// Microcode table: one control word per sequencer step.
`default_nettype none

module rcfd_ucode_rom (
  input  rcfd_pkg::step_e  step_i,
  output rcfd_pkg::ucode_t word_o
);
  import rcfd_pkg::*;

  always_comb begin
    unique case (step_i)
      STEP_IDLE: word_o = '{hold: HOLD_IN,   op: OP_LOAD, jcond: JC_NEVER,
                            jump: STEP_IDLE, next: STEP_CHK};
      STEP_CHK:  word_o = '{hold: HOLD_NONE, op: OP_NOP,  jcond: JC_BAD,
                            jump: STEP_EMIT, next: STEP_ACC};
      STEP_ACC:  word_o = '{hold: HOLD_NONE, op: OP_ACC,  jcond: JC_MORE_IN,
                            jump: STEP_ACC,  next: STEP_DIV};
      STEP_DIV:  word_o = '{hold: HOLD_NONE, op: OP_DIV,  jcond: JC_QUOT_NZ,
                            jump: STEP_DIV,  next: STEP_EMIT};
      STEP_EMIT: word_o = '{hold: HOLD_OUT,  op: OP_EMIT, jcond: JC_MORE_OUT,
                            jump: STEP_EMIT, next: STEP_IDLE};
      default:   word_o = '{hold: HOLD_NONE, op: OP_NOP,  jcond: JC_NEVER,
                            jump: STEP_IDLE, next: STEP_IDLE};
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rcfd_sequencer.sv =====
// Step counter with hold and conditional jump, driven by the microcode table.
`default_nettype none

module rcfd_sequencer (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  rcfd_pkg::status_t   status_i,
  output rcfd_pkg::dp_ctrl_t  ctrl_o,
  output logic                in_ready_o
);
  import rcfd_pkg::*;

  step_e  step_q, step_d;
  ucode_t word;
  logic   go;
  logic   take;

  rcfd_ucode_rom u_rom (
    .step_i (step_q),
    .word_o (word)
  );

  always_comb begin
    unique case (word.hold)
      HOLD_IN:  go = status_i.in_valid;
      HOLD_OUT: go = status_i.out_free;
      default:  go = 1'b1;
    endcase

    unique case (word.jcond)
      JC_BAD:      take = status_i.bad;
      JC_MORE_IN:  take = status_i.more_in;
      JC_QUOT_NZ:  take = status_i.quot_nz;
      JC_MORE_OUT: take = status_i.more_out;
      default:     take = 1'b0;
    endcase

    // hold the step until its wait condition is met
    if (!go) begin
      step_d = step_q;
    end else if (take) begin
      step_d = word.jump;
    end else begin
      step_d = word.next;
    end

    ctrl_o.op   = word.op;
    ctrl_o.fire = go;
    in_ready_o  = (word.hold == HOLD_IN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rcfd_datapath.sv =====
// Datapath: character latch, weighted accumulator, radix divider, digit stack, output beat.
`default_nettype none

module rcfd_datapath (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  rcfd_pkg::dp_ctrl_t              ctrl_i,
  output rcfd_pkg::status_t               status_o,
  input  rcfd_pkg::base_e                 in_base_i,
  input  rcfd_pkg::base_e                 out_base_i,
  input  wire                             in_valid_i,
  input  wire [rcfd_pkg::IN_DATA_W-1:0]   in_data_i,
  input  wire                             out_ready_i,
  output logic                            out_valid_o,
  output logic [rcfd_pkg::CHAR_W-1:0]     out_char_o,
  output logic                            out_last_o,
  output logic                            out_empty_o,
  output logic                            out_bad_o
);
  import rcfd_pkg::*;

  logic [CHAR_W-1:0] char_q [FIELD_COUNT];
  logic [IDX_W-1:0]  cnt_q;
  logic [VAL_W-1:0]  value_q;
  logic              bad_q;
  logic              zero_val_q;
  logic [NDIG_W-1:0] ndig_q;
  logic [DIG_W-1:0]  stack_q [MAX_OUT];

  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q;
  logic              out_empty_q;
  logic              out_bad_q;

  logic              load_bad;
  logic [DIG_W:0]    cur_dv;
  logic [ACC_W-1:0]  acc_sum;
  logic [2*VAL_W-1:0] recip_prod;
  logic [VAL_W-1:0]  quot;
  logic [VAL_W-1:0]  dec_rem;
  logic [DIG_W-1:0]  rem;
  logic [NDIG_W-1:0] ndig_dec;
  logic [DIG_W-1:0]  top_dig;
  logic              out_free;
  logic              fire_load, fire_acc, fire_div, fire_emit;

  assign fire_load = ctrl_i.fire && (ctrl_i.op == OP_LOAD);
  assign fire_acc  = ctrl_i.fire && (ctrl_i.op == OP_ACC);
  assign fire_div  = ctrl_i.fire && (ctrl_i.op == OP_DIV);
  assign fire_emit = ctrl_i.fire && (ctrl_i.op == OP_EMIT);

  // flag any invalid character among the fields in use
  always_comb begin
    load_bad = 1'b0;
    for (int i = 0; i < USED_DIGITS; i++) begin
      if (digit_value(in_data_i[i*CHAR_W +: CHAR_W]) > 5'd15) begin
        load_bad = 1'b1;
      end
    end
  end

  // value * base + digit
  assign cur_dv = digit_value(char_q[cnt_q]);
  always_comb begin
    unique case (in_base_i)
      BASE_BIN: acc_sum = {value_q, 4'b0} >> 3;
      BASE_OCT: acc_sum = {value_q, 4'b0} >> 1;
      BASE_HEX: acc_sum = {value_q, 4'b0};
      default:  acc_sum = {1'b0, value_q, 3'b0} + {3'b0, value_q, 1'b0};
    endcase
    acc_sum = acc_sum + {{(ACC_W-DIG_W){1'b0}}, cur_dv[DIG_W-1:0]};
  end

  // divide by the output base: shifts, or a reciprocal multiply for ten
  assign recip_prod = value_q * RECIP_TEN;
  assign dec_rem    = value_q - ((recip_prod[2*VAL_W-1:RECIP_SH] << 3)
                                 + (recip_prod[2*VAL_W-1:RECIP_SH] << 1));
  always_comb begin
    unique case (out_base_i)
      BASE_BIN: begin
        quot = value_q >> 1;
        rem  = {3'b0, value_q[0]};
      end
      BASE_OCT: begin
        quot = value_q >> 3;
        rem  = {1'b0, value_q[2:0]};
      end
      BASE_HEX: begin
        quot = value_q >> 4;
        rem  = value_q[3:0];
      end
      default: begin
        quot = VAL_W'(recip_prod[2*VAL_W-1:RECIP_SH]);
        rem  = dec_rem[DIG_W-1:0];
      end
    endcase
  end

  assign ndig_dec = ndig_q - 1'b1;
  assign top_dig  = stack_q[ndig_dec[STK_IDX_W-1:0]];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.in_valid = in_valid_i;
    status_o.out_free = out_free;
    status_o.bad      = bad_q;
    status_o.more_in  = (cnt_q != IDX_W'(USED_DIGITS - 1));
    status_o.quot_nz  = (quot != '0);
    status_o.more_out = !bad_q && (ndig_q > NDIG_W'(1));
  end

  always_ff @(posedge clk_i) begin
    if (fire_load) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
        char_q[i] <= in_data_i[i*CHAR_W +: CHAR_W];
      end
      value_q <= '0;
      bad_q   <= load_bad;
    end
    if (fire_acc) begin
      value_q <= acc_sum[VAL_W-1:0];
    end
    if (fire_div) begin
      stack_q[ndig_q[STK_IDX_W-1:0]] <= rem;
      value_q <= quot;
      // note a zero value on the first division
      if (ndig_q == '0) begin
        zero_val_q <= (value_q == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ndig_q <= '0;
    end else begin
      if (fire_load) begin
        cnt_q  <= '0;
        ndig_q <= '0;
      end
      if (fire_acc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (fire_div) begin
        ndig_q <= ndig_q + 1'b1;
      end
      if (fire_emit) begin
        ndig_q <= ndig_dec;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_emit) begin
      out_last_q <= bad_q || (ndig_q == NDIG_W'(1));
      if (bad_q) begin
        out_char_q  <= '0;
        out_empty_q <= 1'b0;
        out_bad_q   <= 1'b1;
      end else if (zero_val_q && out_base_i != BASE_DEC) begin
        // zero in a non-decimal base prints nothing
        out_char_q  <= '0;
        out_empty_q <= 1'b1;
        out_bad_q   <= 1'b0;
      end else begin
        out_char_q  <= (top_dig > DIG_NINE) ? ({4'b0, top_dig} + ALPHA_OFS)
                                            : ({4'b0, top_dig} + ASCII_ZERO);
        out_empty_q <= 1'b0;
        out_bad_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;
  assign out_bad_o   = out_bad_q;

endmodule

`default_nettype wire

// ===== rtl/radix_converter_four_digit_core.sv =====
// Top level of the four-digit ASCII radix converter.
`default_nettype none

// Takes four ASCII digits per input beat (most significant in the lowest byte),
// weighs them in the input base, and streams the value in the output base as
// ASCII characters, most significant first, tlast on the final one. tuser bit 0
// marks zero in a non-decimal base (empty text), bit 1 an invalid input
// character; each of those gives a single beat. A small microcoded sequencer
// runs the job: one step to latch the beat, one to check it, one per input
// digit to accumulate, one per output digit to divide by the output base, and
// one per output digit to emit. The next beat is taken once the last result
// sits in the output register. Base registers are written through the cfg
// port; the user must write them only while the block is idle, which the
// block itself does not enforce.
module radix_converter_four_digit_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire                            cfg_idx_i,
  input  wire [1:0]                      cfg_data_i,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // char_three, char_two, char_one, char_zero from bit 0 up
  input  wire [rcfd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // out_char
  output logic [rcfd_pkg::CHAR_W-1:0]    m_axis_tdata,
  output logic                           m_axis_tlast,
  // empty_result, bad_char from bit 0 up
  output logic [rcfd_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import rcfd_pkg::*;

  base_e    in_base_q;
  base_e    out_base_q;
  status_t  status;
  dp_ctrl_t ctrl;
  logic     out_empty;
  logic     out_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_base_q  <= BASE_DEC;
      out_base_q <= BASE_DEC;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_IN:  in_base_q  <= base_e'(cfg_data_i);
        CFG_IDX_OUT: out_base_q <= base_e'(cfg_data_i);
        default:     in_base_q  <= in_base_q;
      endcase
    end
  end

  rcfd_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (s_axis_tready)
  );

  rcfd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .in_base_i   (in_base_q),
    .out_base_i  (out_base_q),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_empty_o (out_empty),
    .out_bad_o   (out_bad)
  );

  assign m_axis_tuser = {out_bad, out_empty};

endmodule

`default_nettype wire

// ===== tb/radix_converter_four_digit_core_tb.sv =====
// Self-checking testbench for the four-digit ASCII radix converter core.
module radix_converter_four_digit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcfd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 60;

  // packs so that char_three lands in the lowest byte of tdata
  typedef struct packed {
    logic [CHAR_W-1:0] zero;
    logic [CHAR_W-1:0] one;
    logic [CHAR_W-1:0] two;
    logic [CHAR_W-1:0] three;
  } digit_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_char;
    logic              empty_result;
    logic              bad_char;
  } digit_beat_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic                  cfg_idx_i     = 1'b0;
  logic [1:0]            cfg_data_i    = 2'b00;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [CHAR_W-1:0]     m_axis_tdata;
  logic                  m_axis_tlast;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  digit_word_t pending_words[$];
  digit_beat_t expected_digits[$];
  digit_word_t word_on_bus;
  base_e       cur_in_base  = BASE_DEC;
  base_e       cur_out_base = BASE_DEC;
  bit          idle_on      = 1'b1;
  int          error_count  = 0;
  int          cycle_count  = 0;
  int          in_gap       = 0;
  int          out_gap      = 0;
  logic        next_valid;
  logic        next_ready;
  digit_beat_t got_beat;
  digit_beat_t exp_beat;

  radix_converter_four_digit_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int radix_of(base_e b);
    case (b)
      BASE_BIN: return 2;
      BASE_OCT: return 8;
      BASE_DEC: return 10;
      default:  return 16;
    endcase
  endfunction

  // face value of an ASCII digit, -1 for anything but 0-9 and A-F
  function automatic int char_weight(logic [CHAR_W-1:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(int d);
    return (d > 9) ? CHAR_W'(d - 10 + int'("A")) : CHAR_W'(d + int'("0"));
  endfunction

  function automatic void predict_conversion(digit_word_t w);
    logic [CHAR_W-1:0] chars [4];
    int          digs [MAX_OUT];
    int          value;
    int          d;
    int          n;
    int          in_rad;
    int          out_rad;
    digit_beat_t b;
    chars   = '{w.three, w.two, w.one, w.zero};
    in_rad  = radix_of(cur_in_base);
    out_rad = radix_of(cur_out_base);
    value   = 0;
    n       = 0;
    for (int i = 0; i < USED_DIGITS; i++) begin
      d = char_weight(chars[i]);
      if (d < 0) begin
        b = '{8'h00, 1'b1, 1'b0, 1'b1};
        expected_digits.push_back(b);
        return;
      end
      value = value * in_rad + d;
    end
    if (value == 0) begin
      if (out_rad == 10) b = '{digit_char(0), 1'b1, 1'b0, 1'b0};
      else b = '{8'h00, 1'b1, 1'b1, 1'b0};
      expected_digits.push_back(b);
      return;
    end
    while (value > 0 && n < MAX_OUT) begin
      digs[n] = value % out_rad;
      value   = value / out_rad;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      b = '{digit_char(digs[k]), (k == 0), 1'b0, 1'b0};
      expected_digits.push_back(b);
    end
  endfunction

  task automatic report_mismatch(string what, int got_v, int exp_v);
    $display("mismatch on %s: got %0h, expected %0h", what, got_v, exp_v);
    error_count++;
  endtask

  task automatic push_word(logic [CHAR_W-1:0] c3, logic [CHAR_W-1:0] c2,
                           logic [CHAR_W-1:0] c1, logic [CHAR_W-1:0] c0);
    digit_word_t w;
    w = '{c0, c1, c2, c3};
    pending_words.push_back(w);
  endtask

  task automatic push_text(string s);
    push_word(s[0], s[1], s[2], s[3]);
  endtask

  function automatic logic [CHAR_W-1:0] pick_char(base_e b);
    int r;
    int d;
    r = $urandom_range(0, 99);
    if (r < 6) return CHAR_W'($urandom_range(0, 255));
    if (r < 22) d = $urandom_range(0, 15);
    else d = $urandom_range(0, radix_of(b) - 1);
    return digit_char(d);
  endfunction

  // hold until every word is taken and every digit is back, then let the core settle
  task automatic wait_drained();
    while (pending_words.size() != 0 || s_axis_tvalid || expected_digits.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_bases(base_e ib, base_e ob);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDX_IN;
    cfg_data_i <= ib;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_IDX_OUT;
    cfg_data_i <= ob;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_in_base  = ib;
    cur_out_base = ob;
  endtask

  // source side: drive words from the pending queue, predict on each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_conversion(word_on_bus);
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        next_valid = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (idle_on && pending_words.size() != 0 && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 3);
        end else if (pending_words.size() != 0) begin
          word_on_bus = pending_words.pop_front();
          next_valid  = 1'b1;
          s_axis_tdata <= word_on_bus;
        end
        s_axis_tvalid <= next_valid;
      end
    end
  end

  // sink side: check each accepted beat against the oldest expected digit
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_beat = '{m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]};
        if (expected_digits.size() == 0) begin
          report_mismatch("unexpected beat", got_beat, 0);
        end else begin
          exp_beat = expected_digits.pop_front();
          if (got_beat.out_char != exp_beat.out_char)
            report_mismatch("out_char", got_beat.out_char, exp_beat.out_char);
          if (got_beat.last_char != exp_beat.last_char)
            report_mismatch("last_char", got_beat.last_char, exp_beat.last_char);
          if (got_beat.empty_result != exp_beat.empty_result)
            report_mismatch("empty_result", got_beat.empty_result, exp_beat.empty_result);
          if (got_beat.bad_char != exp_beat.bad_char)
            report_mismatch("bad_char", got_beat.bad_char, exp_beat.bad_char);
        end
      end
      next_ready = 1'b1;
      if (out_gap > 0) begin
        out_gap--;
        next_ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_gap    = $urandom_range(0, 3);
        next_ready = 1'b0;
      end
      m_axis_tready <= next_ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    base_e ib;
    base_e ob;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset bases: decimal in, decimal out
    push_text("0000");
    push_text("9999");
    push_text("0001");
    push_text("1A2F");
    push_text("12a4");
    push_text("12G4");
    push_text("/:@F");
    push_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_word(8'h00, 8'h00, 8'h00, 8'h00);

    // largest value, widest binary text
    set_bases(BASE_HEX, BASE_BIN);
    push_text("FFFF");
    push_text("0000");
    push_text("8001");

    // digits at or above the input base still weigh their face value
    set_bases(BASE_BIN, BASE_OCT);
    push_text("1111");
    push_text("9F99");
    push_text("0000");

    set_bases(BASE_OCT, BASE_HEX);
    push_text("7777");
    push_text("0010");
    push_text("0000");

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin ib = BASE_BIN; ob = BASE_BIN; end
        1: begin ib = BASE_HEX; ob = BASE_HEX; end
        2: begin ib = BASE_BIN; ob = BASE_HEX; end
        3: begin ib = BASE_HEX; ob = BASE_BIN; end
        default: begin
          ib = base_e'($urandom_range(0, 3));
          ob = base_e'($urandom_range(0, 3));
        end
      endcase
      set_bases(ib, ob);
      if (p == 7) idle_on = 1'b0;
      for (int n = 0; n < 12; n++) begin
        if ($urandom_range(0, 19) == 0) push_text("0000");
        else push_word(pick_char(ib), pick_char(ib), pick_char(ib), pick_char(ib));
      end
    end

    wait_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
